FILE: sv/bdq_pkg.sv
// Package for the bounded deque: request kinds, result status codes,
// sequencer states and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Largest occupancy the result field can show
  localparam int unsigned OCC_MAX = 31;

  // Default number of entries, and the longest dump run per request
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned MAX_RESULTS  = 16;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_BACK  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_BACK   = 3'd3,
    K_DELETE     = 3'd4,
    K_DUMP_FWD   = 3'd5,
    K_DUMP_REV   = 3'd6
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH,
    ST_SHIFT,
    ST_DUMP
  } state_e;

endpackage

`default_nettype wire

FILE: sv/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/bounded_deque_with_value_delete.sv
// Bounded double-ended queue of signed 32-bit values with delete-by-value.
// Depends on bdq_pkg and bdq_ram.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+---------------------------------
//  request   | in        | start & !busy             | kind_i, value_in_i
//  result    | out       | result_valid_o, one cycle | status_o, value_out_o,
//            |           |                           | occupancy_o, last_o
//
// Push and the empty and full errors finish in the idle state with busy low, so a
// new item may follow at once. Pop reads its entry in ST_POP; delete walks the
// entries in ST_SEARCH and then ST_SHIFT (the search and the shift of the entries
// behind a match form one pass), and a dump gives n results, one per cycle, from
// the entry RAM's single read port, walked one entry per cycle by the sequencer.
// Reset clears head and count; entry contents are not cleared.
// Each result shows for exactly one cycle, in the cycle after it is formed; the
// receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_delete
  import bdq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [KIND_W-1:0]        kind_i,
  input  wire logic signed [DATA_W-1:0] value_in_i,
  output logic                          result_valid_o,
  output logic [STATUS_W-1:0]           status_o,
  output logic signed [DATA_W-1:0]      value_out_o,
  output logic [OCC_W-1:0]              occupancy_o,
  output logic                          last_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned PW    = $clog2(CAPACITY + 3);
  localparam int unsigned SW    = PW + 1;

  // Slot of logical position p, modulo CAPACITY
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                               input logic [PW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(p);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] h);
    return (h == IDX_W'(CAPACITY - 1)) ? '0 : h + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] h);
    return (h == '0) ? IDX_W'(CAPACITY - 1) : h - IDX_W'(1);
  endfunction

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PW-1:0]      ptr_q, ptr_d;
  kind_e              kind_q;
  logic [DATA_W-1:0]  val_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic [PW-1:0]      rd_pos;

  logic               emit;
  status_e            em_status;
  logic [DATA_W-1:0]  em_value;
  logic               em_last;

  logic               rv_q;
  status_e            status_q;
  logic [DATA_W-1:0]  value_q;
  logic [OCC_W-1:0]   occ_q;
  logic               last_q;

  logic               accept;
  kind_e              kind_in;
  logic               full, empty;
  logic [PW-1:0]      cnt_p, dump_n, pos_nx1, pos_nx2;
  logic               at_end1, at_end2, match, dump_last;
  logic [31:0]        cnt_wide;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && (state_q == ST_IDLE);
  assign kind_in = kind_e'(kind_i);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);

  // Shared position arithmetic and the one compare unit
  assign cnt_p     = PW'(count_q);
  assign dump_n    = (cnt_p > PW'(MAX_RESULTS)) ? PW'(MAX_RESULTS) : cnt_p;
  assign pos_nx1   = ptr_q + PW'(1);
  assign pos_nx2   = ptr_q + PW'(2);
  assign at_end1   = (pos_nx1 == cnt_p);
  assign at_end2   = (pos_nx2 == cnt_p);
  assign match     = (ram_rdata == val_q);
  assign dump_last = (pos_nx1 == dump_n);

  // Entry storage
  bdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = slot_of(head_q, rd_pos);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !empty) begin
          unique case (kind_in)
            K_POP_FRONT, K_POP_BACK: state_d = ST_POP;
            K_DELETE:                state_d = ST_SEARCH;
            K_DUMP_FWD, K_DUMP_REV:  state_d = ST_DUMP;
            default:                 state_d = ST_IDLE;
          endcase
        end
      end
      ST_POP: state_d = ST_IDLE;
      ST_SEARCH: begin
        if (match) begin
          state_d = at_end1 ? ST_IDLE : ST_SHIFT;
        end else if (at_end1) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (at_end2) begin
          state_d = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and result forming
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = value_in_i;
    rd_pos    = '0;
    emit      = 1'b0;
    em_status = STAT_OK;
    em_value  = '0;
    em_last   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_in)
            K_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                em_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_dec(head_q);
                head_d    = ring_dec(head_q);
                count_d   = count_q + CNT_W'(1);
              end
            end
            K_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                em_status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(head_q, cnt_p);
                count_d   = count_q + CNT_W'(1);
              end
            end
            K_POP_FRONT, K_POP_BACK, K_DELETE, K_DUMP_FWD, K_DUMP_REV: begin
              // Issue the first read; an empty queue answers at once
              ptr_d  = '0;
              rd_pos = (kind_in == K_POP_BACK || kind_in == K_DUMP_REV)
                       ? cnt_p - PW'(1) : '0;
              if (empty) begin
                emit      = 1'b1;
                em_status = STAT_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        emit     = 1'b1;
        em_value = ram_rdata;
        count_d  = count_q - CNT_W'(1);
        if (kind_q == K_POP_FRONT) begin
          head_d = ring_inc(head_q);
        end
      end
      ST_SEARCH: begin
        // Compare the entry at ptr, prefetch the next one
        rd_pos = pos_nx1;
        if (match) begin
          if (at_end1) begin
            emit     = 1'b1;
            em_value = val_q;
            count_d  = count_q - CNT_W'(1);
          end
        end else if (at_end1) begin
          emit      = 1'b1;
          em_status = STAT_NOT_FOUND;
        end else begin
          ptr_d = pos_nx1;
        end
      end
      ST_SHIFT: begin
        // Move entry ptr+1 up into ptr, prefetch ptr+2
        ram_we    = 1'b1;
        ram_waddr = slot_of(head_q, ptr_q);
        ram_wdata = ram_rdata;
        rd_pos    = pos_nx2;
        ptr_d     = pos_nx1;
        if (at_end2) begin
          emit     = 1'b1;
          em_value = val_q;
          count_d  = count_q - CNT_W'(1);
        end
      end
      ST_DUMP: begin
        emit     = 1'b1;
        em_value = ram_rdata;
        em_last  = dump_last;
        ptr_d    = pos_nx1;
        rd_pos   = (kind_q == K_DUMP_FWD) ? pos_nx1 : cnt_p - PW'(1) - pos_nx1;
      end
      default: ;
    endcase
  end

  assign cnt_wide = 32'(count_d);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      ptr_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      rv_q    <= emit;
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_in;
      val_q  <= value_in_i;
    end
    if (emit) begin
      status_q <= em_status;
      value_q  <= em_value;
      last_q   <= em_last;
      occ_q    <= (cnt_wide > 32'(OCC_MAX)) ? OCC_W'(OCC_MAX) : cnt_wide[OCC_W-1:0];
    end
  end

  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign value_out_o    = value_q;
  assign occupancy_o    = occ_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

FILE: tb/sv/bounded_deque_with_value_delete_tb.sv
// Self-checking testbench for the bounded deque with delete-by-value: a directed
// table, then constrained-by-hand random requests, all scored against a ring model.
// Depends on bdq_pkg and bounded_deque_with_value_delete.
`timescale 1ns / 1ps

module bounded_deque_with_value_delete_tb;
  import bdq_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 320;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 2 * CAP + 8;
  localparam int PRINT_CAP = 100;
  localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  value;
    logic [OCC_W-1:0]          occ;
    logic                      last;
  } result_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [DATA_W-1:0]  value;
    int                        reps;
    logic                      typed;
    status_e                   status;
    logic signed [DATA_W-1:0]  value_out;
    logic [OCC_W-1:0]          occ;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        kind_i = '0;
  logic signed [DATA_W-1:0] value_in_i = '0;
  logic                     result_valid_o;
  logic [STATUS_W-1:0]      status_o;
  logic signed [DATA_W-1:0] value_out_o;
  logic [OCC_W-1:0]         occupancy_o;
  logic                     last_o;

  // Ring model of the deque
  logic signed [DATA_W-1:0] model_slots [CAP];
  int                       model_head = 0;
  int                       model_count = 0;

  result_t expected_results [$];
  result_t want;
  int      mismatch_count = 0;
  int      cycle_count = 0;
  bit      no_idle = 1'b0;

  stim_row_t directed_rows [25];

  bounded_deque_with_value_delete #(
    .CAPACITY(CAP)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .value_in_i    (value_in_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .occupancy_o   (occupancy_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_result(input status_e st, input logic signed [DATA_W-1:0] val,
                             input logic is_last);
    result_t r;
    r.status = st;
    r.value  = val;
    r.occ    = model_count[OCC_W-1:0];
    r.last   = is_last;
    expected_results.push_back(r);
  endtask

  // Apply one accepted item to the ring model and queue the results it causes
  task automatic deque_predict(input logic [KIND_W-1:0] kind,
                               input logic signed [DATA_W-1:0] v);
    int pos;
    int i;
    int n;
    logic signed [DATA_W-1:0] taken;
    case (kind)
      K_PUSH_FRONT, K_PUSH_BACK: begin
        if (model_count >= CAP) begin
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          if (kind == K_PUSH_FRONT) begin
            model_head = (model_head + CAP - 1) % CAP;
            model_slots[model_head] = v;
          end else begin
            model_slots[(model_head + model_count) % CAP] = v;
          end
          model_count++;
          push_result(STAT_OK, '0, 1'b1);
        end
      end
      K_POP_FRONT, K_POP_BACK: begin
        if (model_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          if (kind == K_POP_FRONT) begin
            taken = model_slots[model_head];
            model_head = (model_head + 1) % CAP;
          end else begin
            taken = model_slots[(model_head + model_count - 1) % CAP];
          end
          model_count--;
          push_result(STAT_OK, taken, 1'b1);
        end
      end
      K_DELETE: begin
        if (model_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < model_count && model_slots[(model_head + pos) % CAP] != v) pos++;
          if (pos >= model_count) begin
            push_result(STAT_NOT_FOUND, '0, 1'b1);
          end else begin
            taken = model_slots[(model_head + pos) % CAP];
            // Close the gap: entries behind the match move up one place
            for (i = pos; i + 1 < model_count; i++)
              model_slots[(model_head + i) % CAP] = model_slots[(model_head + i + 1) % CAP];
            model_count--;
            push_result(STAT_OK, taken, 1'b1);
          end
        end
      end
      K_DUMP_FWD, K_DUMP_REV: begin
        if (model_count == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          n = (model_count < MAX_RESULTS) ? model_count : MAX_RESULTS;
          for (i = 0; i < n; i++) begin
            pos = (kind == K_DUMP_FWD) ? i : (model_count - 1 - i);
            push_result(STAT_OK, model_slots[(model_head + pos) % CAP], i + 1 == n);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Mostly short gaps, a few long ones, none during a no-idle stretch
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the item until it is taken, queue its predicted results, then drop start for the picked gap, if any
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] v,
                           input logic typed, input result_t typed_res);
    int gap;
    start      <= 1'b1;
    kind_i     <= kind;
    value_in_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    deque_predict(kind, v);
    // A typed-in row stands in for the single predicted result
    if (typed) begin
      void'(expected_results.pop_back());
      expected_results.push_back(typed_res);
    end
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic stim_row_t mk_row(input logic [KIND_W-1:0] kind,
                                       input logic signed [DATA_W-1:0] value, input int reps,
                                       input logic typed, input status_e st,
                                       input logic signed [DATA_W-1:0] vo,
                                       input logic [OCC_W-1:0] occ);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.reps = reps;
    row.typed = typed;
    row.status = st;
    row.value_out = vo;
    row.occ = occ;
    return row;
  endfunction

  function automatic logic signed [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 6))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd1;
      4: return 32'sd2;
      5: return -32'sd2;
      default: return 32'sd0;
    endcase
  endfunction

  // Random kind, biased toward filling or draining
  function automatic logic [KIND_W-1:0] pick_kind(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 30) return K_PUSH_FRONT;
      if (r < 60) return K_PUSH_BACK;
      if (r < 70) return K_POP_FRONT;
      if (r < 78) return K_POP_BACK;
      if (r < 88) return K_DELETE;
    end else begin
      if (r < 12) return K_PUSH_FRONT;
      if (r < 24) return K_PUSH_BACK;
      if (r < 46) return K_POP_FRONT;
      if (r < 66) return K_POP_BACK;
      if (r < 88) return K_DELETE;
    end
    if (r < 93) return K_DUMP_FWD;
    if (r < 98) return K_DUMP_REV;
    return K_UNUSED;
  endfunction

  // Score each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d value=%0d occ=%0d last=%0d",
                                  status_o, value_out_o, occupancy_o, last_o));
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || value_out_o !== want.value ||
            occupancy_o !== want.occ || last_o !== want.last)
          report_mismatch($sformatf(
              "got status=%0d value=%0d occ=%0d last=%0d, want %0d %0d %0d %0d",
              status_o, value_out_o, occupancy_o, last_o,
              want.status, want.value, want.occ, want.last));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int row_idx;
    int rep;
    int counted;
    bit filling;
    logic [KIND_W-1:0] kind;
    logic signed [DATA_W-1:0] v;
    result_t typed_res;

    // Empty queue errors, the unused kind, extremes, search hits and misses,
    // one-entry delete with and without a match, fill to full, longest walks
    directed_rows[0]  = mk_row(K_POP_FRONT,  0, 1, 1, STAT_EMPTY, 0, 0);
    directed_rows[1]  = mk_row(K_POP_BACK,   0, 1, 1, STAT_EMPTY, 0, 0);
    directed_rows[2]  = mk_row(K_DELETE,     5, 1, 1, STAT_EMPTY, 0, 0);
    directed_rows[3]  = mk_row(K_DUMP_FWD,   0, 1, 1, STAT_EMPTY, 0, 0);
    directed_rows[4]  = mk_row(K_DUMP_REV,   0, 1, 1, STAT_EMPTY, 0, 0);
    directed_rows[5]  = mk_row(K_UNUSED,     32'sh1234, 1, 0, STAT_OK, 0, 0);
    directed_rows[6]  = mk_row(K_PUSH_BACK,  32'sh7FFF_FFFF, 1, 1, STAT_OK, 0, 1);
    directed_rows[7]  = mk_row(K_PUSH_FRONT, 32'sh8000_0000, 1, 1, STAT_OK, 0, 2);
    directed_rows[8]  = mk_row(K_PUSH_BACK,  0, 1, 1, STAT_OK, 0, 3);
    directed_rows[9]  = mk_row(K_PUSH_BACK,  -1, 1, 1, STAT_OK, 0, 4);
    directed_rows[10] = mk_row(K_DUMP_FWD,   0, 1, 0, STAT_OK, 0, 0);
    directed_rows[11] = mk_row(K_DUMP_REV,   0, 1, 0, STAT_OK, 0, 0);
    directed_rows[12] = mk_row(K_DELETE,     12345, 1, 1, STAT_NOT_FOUND, 0, 4);
    directed_rows[13] = mk_row(K_DELETE,     0, 1, 1, STAT_OK, 0, 3);
    directed_rows[14] = mk_row(K_POP_BACK,   0, 1, 1, STAT_OK, -1, 2);
    directed_rows[15] = mk_row(K_POP_FRONT,  0, 1, 1, STAT_OK, 32'sh8000_0000, 1);
    directed_rows[16] = mk_row(K_DELETE,     1, 1, 1, STAT_NOT_FOUND, 0, 1);
    directed_rows[17] = mk_row(K_DELETE,     32'sh7FFF_FFFF, 1, 1, STAT_OK, 32'sh7FFF_FFFF, 0);
    directed_rows[18] = mk_row(K_PUSH_FRONT, 32'sh55AA_0000, CAP, 0, STAT_OK, 0, 0);
    directed_rows[19] = mk_row(K_PUSH_BACK,  1, 1, 1, STAT_FULL, 0, OCC_W'(CAP));
    directed_rows[20] = mk_row(K_PUSH_FRONT, 1, 1, 1, STAT_FULL, 0, OCC_W'(CAP));
    directed_rows[21] = mk_row(K_DUMP_FWD,   0, 1, 0, STAT_OK, 0, 0);
    directed_rows[22] = mk_row(K_DUMP_REV,   0, 1, 0, STAT_OK, 0, 0);
    directed_rows[23] = mk_row(K_DELETE,     32'sh55AA_0000, 1, 0, STAT_OK, 0, 0);
    directed_rows[24] = mk_row(K_DELETE,     32'sh55AA_000F, 1, 0, STAT_OK, 0, 0);

    // Reset once, then release on a clock edge
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    for (row_idx = 0; row_idx < 25; row_idx++) begin
      for (rep = 0; rep < directed_rows[row_idx].reps; rep++) begin
        typed_res.status = directed_rows[row_idx].status;
        typed_res.value  = directed_rows[row_idx].value_out;
        typed_res.occ    = directed_rows[row_idx].occ;
        typed_res.last   = 1'b1;
        send_item(directed_rows[row_idx].kind, directed_rows[row_idx].value + rep,
                  directed_rows[row_idx].typed, typed_res);
      end
    end

    // Random requests, swinging between full and empty
    counted = 0;
    filling = 1'b1;
    typed_res = '0;
    while (counted < RANDOM_ITEMS) begin
      if (filling && model_count == CAP && $urandom_range(0, 1)) filling = 1'b0;
      if (!filling && model_count == 0 && $urandom_range(0, 1)) filling = 1'b1;
      if (counted % 30 == 0) no_idle = ($urandom_range(0, 99) < 30);
      kind = pick_kind(filling);
      if (kind == K_DELETE && model_count > 0 && $urandom_range(0, 99) < 70)
        v = model_slots[(model_head + $urandom_range(0, model_count - 1)) % CAP];
      else if ($urandom_range(0, 99) < 35)
        v = pool_value();
      else
        v = $urandom;
      if (kind != K_UNUSED) counted++;
      send_item(kind, v, 1'b0, typed_res);
    end
    start <= 1'b0;

    // Drain, then watch for stray results
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bounded_deque_with_value_delete.sv
tb/sv/bounded_deque_with_value_delete_tb.sv
